// File: sv/dcd_pkg.sv
// ----------------------------------------------------------------------------
// dcd_pkg: shared types and constants for the dark channel dehaze block
// Request/response structs, register indexes, controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package dcd_pkg;

   localparam int MaxWidthDefault  = 256;
   localparam int MaxHeightDefault = 256;
   localparam int WindowDefault    = 20;

   localparam int CsrIdxWidth  = 2;
   localparam int CsrDataWidth = 9;

   localparam logic [CsrIdxWidth-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_ATMOS_LIGHT  = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_TRANS_FLOOR  = 2'd3;

   localparam logic REQ_WRITE   = 1'b0;
   localparam logic REQ_PROCESS = 1'b1;

   typedef struct packed {
      logic       req_type;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] in_blue;
      logic [7:0] in_green;
      logic [7:0] in_red;
   } req_type_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic [7:0] transmission;
      logic [1:0] dark_index;
      logic       status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, set up window
      logic write_px;   // write captured pixel into frame store
      logic scan_rd;    // issue frame store read at scan pointer
      logic scan_cmp;   // compare returned pixel against best
      logic self_rd;    // read the processed pixel
      logic self_cap;   // capture processed pixel, set up ratios
      logic div_start;  // start next division
      logic div_cap;    // store quotient of finished division
   } dcd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_write;
      logic outside;
      logic scan_last;  // scan pointer on last window pixel
      logic div_done;
      logic div_last;   // current division is the last one
   } dcd_sts_type;

endpackage

`default_nettype wire

// File: sv/dcd_divider.sv
// ----------------------------------------------------------------------------
// dcd_divider: restoring divider, one quotient bit per cycle
// Divides a non-negative numerator by a positive denominator, then rounds
// half to even and saturates the quotient to 0..255.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [16:0] num,
   input  wire logic [8:0]  den,
   output logic             done,
   output logic [7:0]       quot
);

   localparam int NumWidth = 17;
   localparam int DenWidth = 9;

   logic [NumWidth-1:0] q_ff, q_in;
   logic [DenWidth:0]   r_ff, r_in;
   logic [DenWidth-1:0] d_ff, d_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DenWidth:0]   shifted;
   logic [DenWidth+1:0] twice_r;
   logic                round_up;
   logic [NumWidth:0]   q_round;

   // one shift-subtract step per cycle
   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {r_ff[DenWidth-1:0], q_ff[NumWidth-1]};
      if (start) begin
         q_in    = num;
         r_in    = '0;
         d_in    = den;
         cnt_in  = 5'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, d_ff}) begin
            r_in = shifted - {1'b0, d_ff};
            q_in = {q_ff[NumWidth-2:0], 1'b1};
         end else begin
            r_in = shifted;
            q_in = {q_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   // half-even rounding and saturation
   always_comb begin
      twice_r  = {r_ff, 1'b0};
      round_up = (twice_r > {2'b00, d_ff}) ||
                 ((twice_r == {2'b00, d_ff}) && q_ff[0]);
      q_round  = {1'b0, q_ff} + {{NumWidth{1'b0}}, round_up};
      quot     = (q_round > 18'd255) ? 8'd255 : q_round[7:0];
   end

   assign done = done_ff;

endmodule

`default_nettype wire

// File: sv/dcd_datapath.sv
// ----------------------------------------------------------------------------
// dcd_datapath: frame store, window scan and ratio datapath
// Holds the frame store, the configuration registers, the dark channel
// search and the numerators/denominators fed to the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_datapath #(
   parameter int MAX_WIDTH  = dcd_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = dcd_pkg::MaxHeightDefault,
   parameter int WINDOW     = dcd_pkg::WindowDefault
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire dcd_pkg::req_type_type              req_data,
   input  wire logic                               csr_write,
   input  wire logic [dcd_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [dcd_pkg::CsrDataWidth-1:0]   csr_data,
   input  wire dcd_pkg::dcd_cmd_type               cmd,
   output dcd_pkg::dcd_sts_type                    sts,
   output dcd_pkg::rsp_type                        rsp_data
);

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = $clog2(MAX_HEIGHT);
   localparam int AW   = XW + YW;
   localparam int Half = WINDOW / 2;

   // configuration registers
   logic [8:0] width_ff, height_ff;
   logic [7:0] light_ff;
   logic [6:0] floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         light_ff  <= 8'd255;
         floor_ff  <= 7'd54;
      end else if (csr_write) begin
         unique case (csr_index)
            dcd_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            dcd_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            dcd_pkg::CSR_ATMOS_LIGHT:  light_ff  <= csr_data[7:0];
            dcd_pkg::CSR_TRANS_FLOOR:  floor_ff  <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // request capture
   dcd_pkg::req_type_type req_ff;
   logic [12:0] w_eff, h_eff;
   logic [12:0] x_ext, y_ext;

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   always_comb begin
      w_eff = (13'(width_ff) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(width_ff);
      h_eff = (13'(height_ff) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(height_ff);
      x_ext = 13'(req_ff.pos_x);
      y_ext = 13'(req_ff.pos_y);
   end

   // window bounds and scan pointer
   logic [12:0] x0_ff, x1_ff, y1_ff;
   logic [12:0] sx_ff, sy_ff;
   logic [12:0] x0_in, x1_in, y0_in, y1_in;
   logic [12:0] rx_ext, ry_ext;

   always_comb begin
      rx_ext = 13'(req_data.pos_x);
      ry_ext = 13'(req_data.pos_y);
      x0_in  = (rx_ext > 13'(Half)) ? rx_ext - 13'(Half) : '0;
      y0_in  = (ry_ext > 13'(Half)) ? ry_ext - 13'(Half) : '0;
      x1_in  = (rx_ext + 13'(Half) <= w_eff) ? rx_ext + 13'(Half) : w_eff;
      y1_in  = (ry_ext + 13'(Half) <= h_eff) ? ry_ext + 13'(Half) : h_eff;
   end

   assign sts.is_write  = (req_ff.req_type == dcd_pkg::REQ_WRITE);
   assign sts.outside   = (x_ext >= w_eff) || (y_ext >= h_eff);
   assign sts.scan_last = (sx_ff + 13'd1 >= x1_ff) && (sy_ff + 13'd1 >= y1_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x0_ff <= x0_in;
         x1_ff <= x1_in;
         y1_ff <= y1_in;
         sx_ff <= x0_in;
         sy_ff <= y0_in;
      end else if (cmd.scan_rd) begin
         if (sx_ff + 13'd1 >= x1_ff) begin
            sx_ff <= x0_ff;
            sy_ff <= sy_ff + 13'd1;
         end else begin
            sx_ff <= sx_ff + 13'd1;
         end
      end
   end

   // frame store with a separate write and a registered read port
   logic [23:0] store [2**AW];
   logic [23:0] rd_data_ff;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          wr_ok;

   always_comb begin
      wr_addr = {y_ext[YW-1:0], x_ext[XW-1:0]};
      wr_ok   = (x_ext < 13'(MAX_WIDTH)) && (y_ext < 13'(MAX_HEIGHT));
      if (cmd.self_rd) rd_addr = wr_addr;
      else             rd_addr = {sy_ff[YW-1:0], sx_ff[XW-1:0]};
   end

   always_ff @(posedge clock) begin
      if (cmd.write_px && wr_ok) begin
         store[wr_addr] <= {req_ff.in_red, req_ff.in_green, req_ff.in_blue};
      end
      rd_data_ff <= store[rd_addr];
   end

   // dark channel search
   logic [7:0] best_val_ff;
   logic [1:0] best_c_ff;
   logic       first_ff;
   logic [7:0] px_min;
   logic [1:0] px_c;

   always_comb begin
      px_min = rd_data_ff[7:0];
      px_c   = 2'd0;
      if (rd_data_ff[15:8] < px_min) begin
         px_min = rd_data_ff[15:8];
         px_c   = 2'd1;
      end
      if (rd_data_ff[23:16] < px_min) begin
         px_min = rd_data_ff[23:16];
         px_c   = 2'd2;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         first_ff <= 1'b1;
      end else if (cmd.scan_cmp) begin
         first_ff <= 1'b0;
         if (first_ff || (px_min < best_val_ff)) begin
            best_val_ff <= px_min;
            best_c_ff   <= px_c;
         end
      end
   end

   // ratio setup
   logic [8:0]  a_val;
   logic [6:0]  p_val;
   logic [23:0] self_ff;
   logic [7:0]  ic;
   logic        use_t_ff;
   logic [16:0] ap_ff;
   logic [1:0]  div_idx_ff;
   logic [16:0] div_num;
   logic [8:0]  div_den;
   logic [7:0]  v_sel;
   logic signed [18:0] num_s;
   logic [15:0] t_lhs, t_rhs;

   always_comb begin
      a_val = (light_ff == 8'd0) ? 9'd1 : {1'b0, light_ff};
      p_val = (floor_ff == 7'd0) ? 7'd1 : floor_ff;
      unique case (best_c_ff)
         2'd1:    ic = rd_data_ff[15:8];
         2'd2:    ic = rd_data_ff[23:16];
         default: ic = rd_data_ff[7:0];
      endcase
      t_lhs = 16'd100 * 16'(a_val - {1'b0, ic});
      t_rhs = 16'(p_val) * 16'(a_val);
   end

   always_ff @(posedge clock) begin
      if (cmd.self_cap) begin
         self_ff  <= rd_data_ff;
         use_t_ff <= ($signed({1'b0, a_val}) - $signed({2'b0, ic}) >= 0) && (t_lhs >= t_rhs);
         ap_ff    <= 17'(p_val) * 17'(a_val);
      end
   end

   // numerators per division: 0..2 channels, 3 transmission
   logic [7:0] ic_self;
   always_comb begin
      unique case (best_c_ff)
         2'd1:    ic_self = self_ff[15:8];
         2'd2:    ic_self = self_ff[23:16];
         default: ic_self = self_ff[7:0];
      endcase
      unique case (div_idx_ff)
         2'd1:    v_sel = self_ff[15:8];
         2'd2:    v_sel = self_ff[23:16];
         default: v_sel = self_ff[7:0];
      endcase
      if (div_idx_ff == 2'd3) begin
         num_s   = 19'sd255 * ($signed({10'b0, a_val}) - $signed({11'b0, ic_self}));
         div_den = a_val;
      end else if (use_t_ff) begin
         num_s   = $signed({10'b0, a_val}) *
                   ($signed({11'b0, v_sel}) - $signed({11'b0, ic_self}));
         div_den = a_val - {1'b0, ic_self};
      end else begin
         num_s   = $signed({2'b0, ap_ff}) +
                   19'sd100 * ($signed({11'b0, v_sel}) - $signed({10'b0, a_val}));
         div_den = {2'b0, p_val};
      end
      div_num = (num_s <= 0) ? '0 : num_s[16:0];
   end

   logic       div_done;
   logic [7:0] div_quot;

   dcd_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign sts.div_done = div_done;
   assign sts.div_last = (div_idx_ff == 2'd3);

   logic [7:0] res_ff [4];

   always_ff @(posedge clock) begin
      if (cmd.self_cap) begin
         div_idx_ff <= 2'd0;
      end else if (cmd.div_cap) begin
         res_ff[div_idx_ff] <= div_quot;
         div_idx_ff         <= div_idx_ff + 2'd1;
      end
   end

   // response
   always_comb begin
      rsp_data = '0;
      if (sts.outside) begin
         rsp_data.status = 1'b1;
      end else begin
         rsp_data.out_blue     = res_ff[0];
         rsp_data.out_green    = res_ff[1];
         rsp_data.out_red      = res_ff[2];
         rsp_data.transmission = res_ff[3];
         rsp_data.dark_index   = best_c_ff;
      end
   end

endmodule

`default_nettype wire

// File: sv/dcd_ctrl.sv
// ----------------------------------------------------------------------------
// dcd_ctrl: sequencing of one request; a write only stores its pixel
// Process: scan window, read pixel, four divisions, respond; outside: respond.
// ----------------------------------------------------------------------------
`default_nettype none

module dcd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire dcd_pkg::dcd_sts_type  sts,
   output dcd_pkg::dcd_cmd_type       cmd,
   output logic                       busy,
   output logic                       rsp_valid
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_SCAN     = 4'd2;
   localparam logic [3:0] S_DRAIN    = 4'd3;
   localparam logic [3:0] S_SELF_RD  = 4'd4;
   localparam logic [3:0] S_SELF_CAP = 4'd5;
   localparam logic [3:0] S_DIV_GO   = 4'd6;
   localparam logic [3:0] S_DIV_WAIT = 4'd7;
   localparam logic [3:0] S_EMIT     = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       prev_rd_ff;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_write) begin
               cmd.write_px = 1'b1;
               state_in     = S_IDLE;
            end else if (sts.outside) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_SCAN;
            end
         end
         // one read per cycle, compare works on the registered read data
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            cmd.scan_cmp = 1'b1;
            state_in     = S_SELF_RD;
         end
         S_SELF_RD: begin
            cmd.self_rd = 1'b1;
            state_in    = S_SELF_CAP;
         end
         S_SELF_CAP: begin
            cmd.self_cap = 1'b1;
            state_in     = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.div_cap = 1'b1;
               state_in    = sts.div_last ? S_EMIT : S_DIV_GO;
            end
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // compare during scan for the read issued last cycle
      if (state_ff == S_SCAN) cmd.scan_cmp = prev_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         prev_rd_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         prev_rd_ff <= cmd.scan_rd;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // assertions
   a_emit_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response held two cycles");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted request not taken");
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("not idle after response");

endmodule

`default_nettype wire

// File: sv/dark_channel_dehaze_pixel.sv
// ----------------------------------------------------------------------------
// dark_channel_dehaze_pixel: per-pixel dark channel prior dehazing
//
//   channel | ports                         | handshake
//   request | start, busy, req_data         | taken when start && !busy
//   result  | rsp_valid, rsp_data           | one-cycle strobe, no stall
//   config  | csr_write, csr_index, csr_data| written when csr_write
//
// A write item stores its pixel; a process item outside the image only
// responds. A process item scans the clipped window (up to 400 pixels)
// through the single frame store read port, then runs four divisions
// one after another on the bit-serial divider.
// Reset clears control and restores register defaults; store contents are
// undefined until written. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module dark_channel_dehaze_pixel #(
   parameter int MAX_WIDTH  = dcd_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = dcd_pkg::MaxHeightDefault,
   parameter int WINDOW     = dcd_pkg::WindowDefault
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire dcd_pkg::req_type_type              req_data,
   output logic                                    rsp_valid,
   output dcd_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_write,
   input  wire logic [dcd_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [dcd_pkg::CsrDataWidth-1:0]   csr_data
);

   dcd_pkg::dcd_cmd_type cmd;
   dcd_pkg::dcd_sts_type sts;

   dcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   dcd_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .WINDOW     (WINDOW)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
